[hw/rtl/sna_pkg.sv]
// Shared types and constants of the sequence number allocator.
package sna_pkg;

   localparam int NUMBER_W = 64;
   localparam int OP_W     = 3;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_RESERVE  = 3'd0,
      OP_RELEASE  = 3'd1,
      OP_CONFIRM  = 3'd2,
      OP_ROLLBACK = 3'd3,
      OP_PROPOSE  = 3'd4
   } sna_op_type;

   // Response status codes
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FULL = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SUM,
      S_OFFSET,
      S_UNMARK,
      S_CONF_APPLY,
      S_SHIFT,
      S_RB_CHECK,
      S_DONE
   } sna_state_type;

   // Controls broadcast to every window cell
   typedef struct packed {
      logic clear_all;
      logic shift_down;
      logic shift_up;
      logic clear_sel;
   } sna_cell_ctrl_type;

endpackage

[hw/rtl/sna_cell.sv]
// One bit of the pending window, shiftable in either direction.
module sna_cell
   import sna_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sna_cell_ctrl_type ctrl,
   input  logic              sel,
   input  logic              upper_bit,
   input  logic              lower_bit,
   output logic              bit_q
);

   logic pend_ff;
   logic pend_in;

   // Priority: clear, slide down, slide up, addressed clear, hold
   always_comb begin
      pend_in = pend_ff;
      if (ctrl.clear_all) begin
         pend_in = 1'b0;
      end else if (ctrl.shift_down) begin
         pend_in = upper_bit;
      end else if (ctrl.shift_up) begin
         pend_in = lower_bit;
      end else if (ctrl.clear_sel && sel) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign bit_q = pend_ff;

endmodule

[hw/rtl/sequence_number_allocator_unit.sv]
// Sequence number allocator: a row of window cells driven by a sequencer.
//
// Requests arrive on the req_ channel (op, nonce, is_own_address) and each
// produces exactly one response word on the rsp_ channel (next_number,
// status). A word moves when valid is high and stall is low.
// The block works on one request at a time; req_stall is high while busy.
// Steps from acceptance to the response being offered:
//   reserve / propose : a search, which rotates the cell ring once past
//                       the cell at its bottom end, then a sum
//   release           : offset, then unmark
//   rollback (own)    : check, offset, then unmark
//   confirm (own)     : offset, apply, then one shift per bit the window
//                       slides down, or none when it clears outright
//   anything else     : straight to the response
// The response sits in an output register, so the next request is taken
// while a finished response still waits for the receiver; a held rsp_stall
// keeps that word steady and holds back only the word after it.
// Reset clears the confirmed number and every pending bit at once.
module sequence_number_allocator_unit
   import sna_pkg::*;
#(
   parameter int WINDOW = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [NUMBER_W-1:0] req_nonce,
   input  logic                req_is_own_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [NUMBER_W-1:0] rsp_next_number,
   output logic                rsp_status
);

   localparam int IW = $clog2(WINDOW);

   // Sequencer and datapath registers
   sna_state_type       state_ff, state_in;
   sna_op_type          op_ff, op_in;
   logic [NUMBER_W-1:0] nonce_ff, nonce_in;
   logic                valid_ff, valid_in;
   logic [NUMBER_W-1:0] value_ff, value_in;
   logic [NUMBER_W-1:0] base_ff, base_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       found_idx_ff, found_idx_in;
   logic                off_ok_ff, off_ok_in;
   logic                off_big_ff, off_big_in;
   logic [IW-1:0]       off_idx_ff, off_idx_in;
   logic                gt_ff, gt_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic [NUMBER_W-1:0] res_next_ff, res_next_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_W-1:0] rsp_next_ff, rsp_next_in;
   logic                rsp_status_ff, rsp_status_in;

   sna_cell_ctrl_type   cell_ctrl;
   logic [WINDOW-1:0]   win_bits;
   logic                top_fill;
   logic                req_take;
   logic [NUMBER_W-1:0] diff;

   assign req_take = req_valid && (state_ff == S_IDLE);
   assign diff     = nonce_ff - base_ff;

   // Next state, datapath updates and cell controls
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      nonce_in      = nonce_ff;
      valid_in      = valid_ff;
      value_in      = value_ff;
      base_in       = base_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      off_ok_in     = off_ok_ff;
      off_big_in    = off_big_ff;
      off_idx_in    = off_idx_ff;
      gt_in         = gt_ff;
      cnt_in        = cnt_ff;
      res_next_in   = res_next_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_next_in   = rsp_next_ff;
      rsp_status_in = rsp_status_ff;
      cell_ctrl     = '0;
      top_fill      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in         = sna_op_type'(req_op);
               nonce_in      = req_nonce;
               res_next_in   = '0;
               res_status_in = ST_OK;
               pos_in        = '0;
               found_in      = 1'b0;
               case (sna_op_type'(req_op))
                  OP_RESERVE, OP_PROPOSE: state_in = S_SCAN;
                  OP_RELEASE:             state_in = S_OFFSET;
                  OP_CONFIRM:  state_in = req_is_own_address ? S_OFFSET : S_DONE;
                  OP_ROLLBACK: state_in = req_is_own_address ? S_RB_CHECK : S_DONE;
                  default:                state_in = S_DONE;
               endcase
            end
         end

         // Rotate the ring once; the bottom cell is inspected each cycle
         S_SCAN: begin
            cell_ctrl.shift_down = 1'b1;
            top_fill = win_bits[0] |
                       ((op_ff == OP_RESERVE) && !found_ff && !win_bits[0]);
            if (!found_ff && !win_bits[0]) begin
               found_in     = 1'b1;
               found_idx_in = pos_ff;
            end
            if (pos_ff == IW'(WINDOW - 1)) begin
               state_in = S_SUM;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         S_SUM: begin
            if (found_ff) begin
               res_next_in = base_ff + NUMBER_W'(found_idx_ff);
            end else begin
               res_status_in = ST_FULL;
            end
            state_in = S_DONE;
         end

         // Offset of the nonce from the window base
         S_OFFSET: begin
            off_ok_in  = diff < NUMBER_W'(WINDOW);
            off_big_in = diff >= NUMBER_W'(WINDOW - 1);
            off_idx_in = diff[IW-1:0];
            gt_in      = nonce_ff > value_ff;
            state_in   = (op_ff == OP_CONFIRM) ? S_CONF_APPLY : S_UNMARK;
         end

         S_UNMARK: begin
            cell_ctrl.clear_sel = off_ok_ff;
            state_in = S_DONE;
         end

         // Raise a lower or unset confirmed number; slide or clear the window
         S_CONF_APPLY: begin
            state_in = S_DONE;
            if (!valid_ff || gt_ff) begin
               valid_in = 1'b1;
               value_in = nonce_ff;
               base_in  = nonce_ff + 1'b1;
               if (off_big_ff) begin
                  cell_ctrl.clear_all = 1'b1;
               end else begin
                  cnt_in   = off_idx_ff + 1'b1;
                  state_in = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            cell_ctrl.shift_down = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == IW'(1)) begin
               state_in = S_DONE;
            end
         end

         // Step back a confirmed number equal to the nonce, then unmark the nonce
         S_RB_CHECK: begin
            if (valid_ff && (nonce_ff == value_ff)) begin
               cell_ctrl.shift_up = 1'b1;
               base_in = value_ff;
               if (value_ff != '0) begin
                  value_in = value_ff - 1'b1;
               end else begin
                  valid_in = 1'b0;
               end
            end
            state_in = S_OFFSET;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_next_in   = res_next_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= 1'b0;
         value_ff     <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         value_ff     <= value_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      nonce_ff      <= nonce_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      off_ok_ff     <= off_ok_in;
      off_big_ff    <= off_big_in;
      off_idx_ff    <= off_idx_in;
      gt_ff         <= gt_in;
      cnt_ff        <= cnt_in;
      res_next_ff   <= res_next_in;
      res_status_ff <= res_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Row of window cells; bit i stands for base + i
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic upper;
      logic lower;
      if (i == WINDOW - 1) begin : g_top
         assign upper = top_fill;
      end else begin : g_mid_up
         assign upper = win_bits[i+1];
      end
      if (i == 0) begin : g_bottom
         assign lower = 1'b0;
      end else begin : g_mid_dn
         assign lower = win_bits[i-1];
      end
      sna_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .sel       (off_idx_ff == IW'(i)),
         .upper_bit (upper),
         .lower_bit (lower),
         .bit_q     (win_bits[i])
      );
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_number = rsp_next_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[tb/testbench.sv]
// Testbench of the sequence number allocator: scoreboard, stimulus and response checks.
`timescale 1ns / 1ps

module testbench;
   import sna_pkg::*;

   localparam int WINDOW      = 64;
   localparam int ITEMS       = 850;
   localparam int TAIL_ITEMS  = 9;
   localparam int HOLD_CYCLES = 80;

   // Op codes the block does not use
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [NUMBER_W-1:0] TOP_NUMBER = '1;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic                status;
   } response_type;

   // Mirror of the allocator state and the responses still owed by the block
   class number_scoreboard_type;
      logic                conf_valid;
      logic [NUMBER_W-1:0] conf_value;
      logic [WINDOW-1:0]   pending;
      response_type        owed_q[$];
      int                  mismatches;
      int                  checked;
      int                  full_answers;
      int                  slides;
      int                  rollbacks;

      function new();
         conf_valid   = 1'b0;
         conf_value   = '0;
         pending      = '0;
         mismatches   = 0;
         checked      = 0;
         full_answers = 0;
         slides       = 0;
         rollbacks    = 0;
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      // Bit 0 stands for the number above the confirmed one, or zero if none
      function logic [NUMBER_W-1:0] window_base();
         logic [NUMBER_W-1:0] base;
         base = conf_valid ? conf_value + 1 : '0;
         return base;
      endfunction

      function void drop_number(logic [NUMBER_W-1:0] number);
         logic [NUMBER_W-1:0] offset;
         offset = number - window_base();
         if (offset < WINDOW) pending[int'(offset)] = 1'b0;
      endfunction

      // Work out the response to an accepted request word and update the mirror
      function void note_request(logic [OP_W-1:0] op, logic [NUMBER_W-1:0] nonce, logic own);
         response_type        answer;
         logic [NUMBER_W-1:0] rise;
         int                  slot;
         answer.number = '0;
         answer.status = ST_OK;
         case (op)
            OP_RESERVE, OP_PROPOSE: begin
               slot = -1;
               for (int i = WINDOW - 1; i >= 0; i--) if (!pending[i]) slot = i;
               if (slot < 0) begin
                  answer.status = ST_FULL;
                  full_answers++;
               end else begin
                  answer.number = window_base() + slot;
                  if (op == OP_RESERVE) pending[slot] = 1'b1;
               end
            end
            OP_RELEASE: drop_number(nonce);
            OP_CONFIRM: if (own) begin
               if (!conf_valid) begin
                  // base rises from zero to nonce + 1
                  if (nonce >= WINDOW) pending = '0;
                  else pending = pending >> (nonce + 1);
                  conf_valid = 1'b1;
                  conf_value = nonce;
                  slides++;
               end else if (nonce > conf_value) begin
                  rise = nonce - conf_value;
                  if (rise >= WINDOW) pending = '0;
                  else pending = pending >> rise;
                  conf_value = nonce;
                  slides++;
               end
            end
            OP_ROLLBACK: if (own) begin
               if (conf_valid && nonce == conf_value) begin
                  pending = pending << 1;
                  if (conf_value != '0) conf_value = conf_value - 1;
                  else conf_valid = 1'b0;
                  rollbacks++;
               end
               drop_number(nonce);
            end
            default: ;
         endcase
         owed_q.push_back(answer);
      endfunction

      // Compare a response word with the oldest one owed
      function void check_response(logic [NUMBER_W-1:0] number, logic status);
         response_type want;
         if (owed_q.size() == 0) begin
            $error("unexpected response: next_number %0h status %0b", number, status);
            mismatches++;
         end else begin
            want = owed_q.pop_front();
            checked++;
            if (number !== want.number) begin
               $error("next_number: expected %0h, actual %0h", want.number, number);
               mismatches++;
            end
            if (status !== want.status) begin
               $error("status: expected %0b, actual %0b", want.status, status);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op             = OP_RESERVE;
   logic [NUMBER_W-1:0] req_nonce          = '0;
   logic                req_is_own_address = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [NUMBER_W-1:0] rsp_next_number;
   logic                rsp_status;

   number_scoreboard_type tracker = new();

   bit steady_phase  = 1'b0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int random_count  = 0;

   sequence_number_allocator_unit #(.WINDOW(WINDOW)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_nonce          (req_nonce),
      .req_is_own_address (req_is_own_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_number    (rsp_next_number),
      .rsp_status         (rsp_status)
   );

   always #10 clock = ~clock;

   // Watch both channels; a response is checked before a new request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_response(rsp_next_number, rsp_status);
         if (req_valid && !req_stall) tracker.note_request(req_op, req_nonce, req_is_own_address);
      end
   end

   // Receiver: random stalls, none in the steady phase, long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !steady_phase && ($urandom_range(0, 99) < 19);
      end
   end

   // Offer one request word, hold it until taken, then maybe idle a while
   task automatic send_request(input logic [OP_W-1:0] op, input logic [NUMBER_W-1:0] nonce,
                               input logic own);
      req_valid          <= 1'b1;
      req_op             <= op;
      req_nonce          <= nonce;
      req_is_own_address <= own;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!steady_phase) begin
         while ($urandom_range(0, 99) < 19) begin
            req_valid <= 1'b0;
            req_nonce <= {$urandom, $urandom};
            @(posedge clock);
         end
      end
   endtask

   // Sender goes quiet until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [NUMBER_W-1:0] release_pick();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return tracker.window_base() + $urandom_range(0, WINDOW + 3);
      if (roll < 90) return tracker.window_base() - $urandom_range(1, 4);
      return {$urandom, $urandom};
   endfunction

   // Mostly small rises so the window slides; huge values only late in the run
   function automatic logic [NUMBER_W-1:0] confirm_pick();
      int roll;
      roll = $urandom_range(0, 99);
      if (!tracker.conf_valid) return NUMBER_W'($urandom_range(0, WINDOW + 4));
      if (roll < 60) return tracker.conf_value + $urandom_range(0, 8);
      if (roll < 85) return tracker.conf_value + $urandom_range(9, WINDOW + 10);
      if (roll < 97 || random_count < 700) begin
         if (tracker.conf_value < 8) return tracker.conf_value;
         return tracker.conf_value - $urandom_range(0, 5);
      end
      return {$urandom, $urandom};
   endfunction

   function automatic logic [NUMBER_W-1:0] rollback_pick();
      if ($urandom_range(0, 9) < 8) return tracker.conf_value;
      return tracker.window_base() + $urandom_range(0, WINDOW + 2);
   endfunction

   // A run of random requests; a filling run drives the window to full
   task automatic random_burst(input int length, input bit filling);
      logic [OP_W-1:0]     op;
      logic [NUMBER_W-1:0] nonce;
      logic                own;
      int                  roll;
      for (int n = 0; n < length && items_sent < ITEMS - TAIL_ITEMS; n++) begin
         roll  = $urandom_range(0, 99);
         nonce = {$urandom, $urandom};
         own   = 1'b1;
         if (filling) begin
            op = (roll < 90) ? OP_RESERVE : OP_PROPOSE;
         end else if (roll < 34) begin
            op = OP_RESERVE;
         end else if (roll < 44) begin
            op = OP_PROPOSE;
         end else if (roll < 64) begin
            op    = OP_RELEASE;
            nonce = release_pick();
         end else if (roll < 79) begin
            op    = OP_CONFIRM;
            nonce = confirm_pick();
         end else if (roll < 93) begin
            op    = OP_ROLLBACK;
            nonce = rollback_pick();
            own   = ($urandom_range(0, 9) != 0);
         end else if (roll < 97) begin
            op = OP_SPARE_FIRST +
                 OP_W'($urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
         end else begin
            op  = ($urandom_range(0, 1) != 0) ? OP_CONFIRM : OP_ROLLBACK;
            own = 1'b0;
         end
         send_request(op, nonce, own);
         if (own && op <= OP_PROPOSE) random_count++;
      end
   endtask

   // Main sequence
   initial begin
      int bursts;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fresh window, release, foreign address, slides, invalidation
      send_request(OP_PROPOSE,  '0, 1'b0);
      send_request(OP_RESERVE,  TOP_NUMBER, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b0);
      send_request(OP_RESERVE,  '0, 1'b1);
      send_request(OP_RELEASE,  64'd1, 1'b1);
      send_request(OP_RELEASE,  TOP_NUMBER, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b1);
      send_request(OP_CONFIRM,  64'd5, 1'b0);
      send_request(OP_ROLLBACK, 64'd0, 1'b0);
      send_request(OP_CONFIRM,  64'd1, 1'b1);
      send_request(OP_PROPOSE,  '0, 1'b1);
      send_request(OP_ROLLBACK, 64'd1, 1'b1);
      send_request(OP_ROLLBACK, 64'd0, 1'b1);
      send_request(OP_SPARE_FIRST, TOP_NUMBER, 1'b1);
      send_request(OP_SPARE_LAST,  '0, 1'b0);
      send_request(OP_CONFIRM,  64'd100, 1'b1);
      send_request(OP_CONFIRM,  64'd99, 1'b1);
      send_request(OP_ROLLBACK, 64'd50, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b1);
      drain();

      // Random part: filling runs and mixed runs, with one steady stretch
      bursts = 0;
      while (items_sent < ITEMS - TAIL_ITEMS) begin
         steady_phase = (bursts >= 6 && bursts < 9);
         if (bursts == 3) hold_requests++;
         if (bursts % 7 == 5) drain();
         if ($urandom_range(0, 3) == 0) random_burst(WINDOW + 6, 1'b1);
         else random_burst($urandom_range(20, 40), 1'b0);
         bursts++;
      end
      steady_phase = 1'b0;

      // Top of the number range: base wraps to zero
      send_request(OP_CONFIRM,  TOP_NUMBER, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b1);
      send_request(OP_CONFIRM,  TOP_NUMBER - 1, 1'b1);
      send_request(OP_ROLLBACK, TOP_NUMBER, 1'b1);
      send_request(OP_RESERVE,  '0, 1'b1);
      send_request(OP_PROPOSE,  '0, 1'b1);
      send_request(OP_RELEASE,  64'd0, 1'b1);
      send_request(OP_PROPOSE,  '0, 1'b1);

      drain();
      repeat (WINDOW + 8) @(posedge clock);

      $display("%0d requests sent, %0d responses checked", items_sent, tracker.checked);
      $display("%0d window-full answers, %0d window slides, %0d rollbacks",
               tracker.full_answers, tracker.slides, tracker.rollbacks);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #30_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
